// ===== rtl/api_frame_receive_parser_unit_assert.svh =====
// assertion macros for the api frame receive parser
`ifndef API_FRAME_RECEIVE_PARSER_UNIT_ASSERT_SVH
`define API_FRAME_RECEIVE_PARSER_UNIT_ASSERT_SVH

// same-cycle implication on clk, disabled during reset
`define AFRP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, disabled during reset
`define AFRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/afrp_pkg.sv =====
// shared types and constants for the api frame receive parser
package afrp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;
	localparam int unsigned IN_TDATA_W = 8;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [BYTE_W-1:0] START_DELIM_RESET = 8'h7E;
	localparam logic [BYTE_W-1:0] CHECKSUM_BASE = 8'hFF;

	// word index of each register
	localparam logic REG_START_DELIM = 1'b0;

	typedef enum logic [2:0] {
		PH_HUNT     = 3'd0,
		PH_LEN_HI   = 3'd1,
		PH_LEN_LO   = 3'd2,
		PH_PAYLOAD  = 3'd3,
		PH_CHECKSUM = 3'd4
	} afrp_phase_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] payload_byte;
		logic              frame_end;
		logic              checksum_ok;
		logic [LEN_W-1:0]  frame_length;
	} afrp_result_t;

endpackage

// ===== rtl/afrp_cfg.sv =====
// apb register file holding the start delimiter
module afrp_cfg
	import afrp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [BYTE_W-1:0] start_delimiter
);

	logic [BYTE_W-1:0] start_delim_q;
	logic              hit_delim;

	assign pready = 1'b1;
	assign hit_delim = (paddr[2] == REG_START_DELIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delim_q <= START_DELIM_RESET;
		end else if (psel && penable && pwrite && pready && hit_delim) begin
			start_delim_q <= pwdata[BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit_delim) begin
			prdata = {{(APB_DW-BYTE_W){1'b0}}, start_delim_q};
		end
	end

	assign start_delimiter = start_delim_q;

endmodule

// ===== rtl/afrp_parse.sv =====
// frame parse state and per-byte result logic
module afrp_parse
	import afrp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [BYTE_W-1:0] start_delimiter,
	output afrp_result_t      result
);

	afrp_phase_t       phase_q, phase_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  cnt_q, cnt_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [LEN_W-1:0]  cnt_inc;
	logic [BYTE_W-1:0] expect_sum;

	assign cnt_inc = cnt_q + 1'b1;
	assign expect_sum = CHECKSUM_BASE - sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q;
		result  = '0;
		case (phase_q)
			PH_LEN_HI: begin
				len_d   = {rx_byte, {(LEN_W-BYTE_W){1'b0}}};
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d   = len_q | {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
				cnt_d   = '0;
				sum_d   = '0;
				phase_d = (len_d == '0) ? PH_CHECKSUM : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_d   = sum_q + rx_byte;
				cnt_d   = cnt_inc;
				if (cnt_inc >= len_q) begin
					phase_d = PH_CHECKSUM;
				end
				result.valid        = 1'b1;
				result.payload_byte = rx_byte;
				result.frame_length = len_q;
			end
			PH_CHECKSUM: begin
				result.valid        = 1'b1;
				result.frame_end    = 1'b1;
				result.checksum_ok  = (rx_byte == expect_sum);
				result.frame_length = len_q;
				phase_d = PH_HUNT;
				len_d   = '0;
				cnt_d   = '0;
				sum_d   = '0;
			end
			default: begin
				if (rx_byte == start_delimiter) begin
					len_d   = '0;
					cnt_d   = '0;
					sum_d   = '0;
					phase_d = PH_LEN_HI;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

endmodule

// ===== rtl/api_frame_receive_parser_unit.sv =====
// top level of the api frame receive parser
// Usage:
// - s_* carries received bytes, one per item, in s_tdata[7:0].
// - m_* carries results: m_tdata[7:0] payload byte (zero on frame end),
//   m_tdata[23:8] declared frame length, m_tlast frame end, m_tuser checksum ok.
// - apb port holds the start delimiter at address 0 (reset 0x7e); write it
//   only while no item is in flight.
// - bytes are hunted until the start delimiter, then two length bytes, the
//   payload bytes (each forwarded as an item) and the checksum byte, which
//   gives the frame-end item; header bytes and hunted bytes give no item.
// - an accepted byte is held in the input register until the parser advances,
//   and its result is then registered in the output register that drives m_tvalid.
// - one byte per cycle sustained while m_tready stays high; the whole parse step lies
//   between the input register and the output register.
// - when m_tready is low the output register holds and the input register
//   fills; s_tready drops only when both are occupied.
// - reset clears both registers and returns the parser to hunting.
`include "api_frame_receive_parser_unit_assert.svh"

module api_frame_receive_parser_unit
	import afrp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [7:0] rx_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [7:0] payload_byte, [23:8] frame_length
	output logic                   m_tlast,
	output logic                   m_tuser,  // [0] checksum_ok
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	afrp_result_t      res_s2;
	afrp_result_t      res;
	logic              advance;
	logic              out_free;
	logic [BYTE_W-1:0] start_delimiter;

	afrp_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.start_delimiter (start_delimiter)
	);

	afrp_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.rx_byte         (byte_s1),
		.start_delimiter (start_delimiter),
		.result          (res)
	);

	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[BYTE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.frame_length, res_s2.payload_byte};
	assign m_tlast  = res_s2.frame_end;
	assign m_tuser  = res_s2.checksum_ok;

	`AFRP_ASSERT_SAME(a_end_zero_payload, m_tvalid && m_tlast, m_tdata[BYTE_W-1:0] == '0,
		"frame-end item carries a nonzero payload byte")
	`AFRP_ASSERT_SAME(a_ok_only_on_end, m_tvalid && m_tuser, m_tlast,
		"checksum ok set on a payload item")
	`AFRP_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(byte_s1),
		"input register lost a stalled item")
	`AFRP_ASSERT_SAME(a_ready_full, !s_tready, valid_s1 && valid_s2 && !m_tready,
		"input stalled while a register was free")

endmodule

// ===== verif/api_frame_receive_parser_unit_tb.sv =====
// testbench for the api frame receive parser: directed table and random frames vs a predictor
`timescale 1ns / 1ps

module api_frame_receive_parser_unit_tb;
	import afrp_pkg::*;

	typedef struct {
		logic [BYTE_W-1:0] rx;
		bit                typed;
		bit                gives;
		afrp_result_t      res;
	} stim_row_t;

	localparam logic [APB_AW-1:0] DELIM_ADDR = APB_AW'(4 * REG_START_DELIM);
	localparam int DIRECTED_ROWS = 18;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;  // [7:0] rx_byte
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;  // [7:0] payload_byte, [23:8] frame_length
	logic                   m_tlast;
	logic                   m_tuser;  // [0] checksum_ok
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_AW-1:0]      paddr = '0;
	logic [APB_DW-1:0]      pwdata = '0;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;

	// predictor state
	afrp_phase_t       parse_ph = PH_HUNT;
	logic [LEN_W-1:0]  hdr_len = '0;
	logic [LEN_W-1:0]  pay_count = '0;
	logic [BYTE_W-1:0] pay_sum = '0;
	logic [BYTE_W-1:0] start_delim = START_DELIM_RESET;

	afrp_result_t results_due [$];
	int           errors = 0;
	int           items_sent = 0;
	int           idle_pct = 7;
	int           stall_pct = 7;

	// frames against the reset delimiter
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{rx: 8'h00, typed: 1'b1, gives: 1'b0, res: '0},
		'{rx: 8'hFF, typed: 1'b1, gives: 1'b0, res: '0},
		'{rx: 8'h7E, typed: 1'b1, gives: 1'b0, res: '0},
		'{rx: 8'h00, typed: 1'b1, gives: 1'b0, res: '0},
		'{rx: 8'h00, typed: 1'b1, gives: 1'b0, res: '0},
		'{rx: 8'hFF, typed: 1'b1, gives: 1'b1, res: '{1'b1, 8'h00, 1'b1, 1'b1, 16'd0}},
		'{rx: 8'h7E, typed: 1'b1, gives: 1'b0, res: '0},
		'{rx: 8'h00, typed: 1'b1, gives: 1'b0, res: '0},
		'{rx: 8'h03, typed: 1'b1, gives: 1'b0, res: '0},
		'{rx: 8'h7E, typed: 1'b1, gives: 1'b1, res: '{1'b1, 8'h7E, 1'b0, 1'b0, 16'd3}},
		'{rx: 8'hFF, typed: 1'b0, gives: 1'b0, res: '0},
		'{rx: 8'h00, typed: 1'b0, gives: 1'b0, res: '0},
		'{rx: 8'h82, typed: 1'b0, gives: 1'b0, res: '0},
		'{rx: 8'h7E, typed: 1'b1, gives: 1'b0, res: '0},
		'{rx: 8'h00, typed: 1'b1, gives: 1'b0, res: '0},
		'{rx: 8'h01, typed: 1'b1, gives: 1'b0, res: '0},
		'{rx: 8'h55, typed: 1'b0, gives: 1'b0, res: '0},
		'{rx: 8'h00, typed: 1'b1, gives: 1'b1, res: '{1'b1, 8'h00, 1'b1, 1'b0, 16'd1}}
	};

	api_frame_receive_parser_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	task automatic parse_rx_byte(input logic [BYTE_W-1:0] b, output bit gives,
		output afrp_result_t res);
		res = '0;
		gives = 1'b0;
		case (parse_ph)
			PH_LEN_HI: begin
				hdr_len = {b, 8'h00};
				parse_ph = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				hdr_len[7:0] = b;
				pay_count = '0;
				pay_sum = '0;
				parse_ph = (hdr_len == '0) ? PH_CHECKSUM : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				pay_sum = pay_sum + b;
				pay_count = pay_count + 1'b1;
				if (pay_count >= hdr_len) begin
					parse_ph = PH_CHECKSUM;
				end
				res = '{1'b1, b, 1'b0, 1'b0, hdr_len};
				gives = 1'b1;
			end
			PH_CHECKSUM: begin
				res = '{1'b1, 8'h00, 1'b1, (b == BYTE_W'(CHECKSUM_BASE - pay_sum)), hdr_len};
				gives = 1'b1;
				parse_ph = PH_HUNT;
				hdr_len = '0;
				pay_count = '0;
				pay_sum = '0;
			end
			default: begin
				if (b == start_delim) begin
					hdr_len = '0;
					pay_count = '0;
					pay_sum = '0;
					parse_ph = PH_LEN_HI;
				end else begin
					parse_ph = PH_HUNT;
				end
			end
		endcase
	endtask

	// output item check, sampled half a cycle ahead of the accepting edge
	always @(negedge clk) begin : result_check
		afrp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				report_mismatch("item with none due", 32'(m_tdata), 32'd0);
			end else begin
				want = results_due.pop_front();
				if (m_tdata[7:0] !== want.payload_byte)
					report_mismatch("payload_byte", 32'(m_tdata[7:0]),
						32'(want.payload_byte));
				if (m_tdata[23:8] !== want.frame_length)
					report_mismatch("frame_length", 32'(m_tdata[23:8]),
						32'(want.frame_length));
				if (m_tlast !== want.frame_end)
					report_mismatch("frame_end", 32'(m_tlast), 32'(want.frame_end));
				if (m_tuser !== want.checksum_ok)
					report_mismatch("checksum_ok", 32'(m_tuser), 32'(want.checksum_ok));
			end
		end
	end

	task automatic send_row(input stim_row_t row);
		bit           offered;
		bit           took;
		bit           gives;
		afrp_result_t res;
		offered = 1'b0;
		took = 1'b0;
		while (!took) begin
			if (!offered && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end else begin
				if (!offered) begin
					s_tvalid <= 1'b1;
					s_tdata <= row.rx;
					offered = 1'b1;
				end
				@(negedge clk);
				if (s_tready) begin
					took = 1'b1;
					parse_rx_byte(row.rx, gives, res);
					if (row.typed) begin
						if (row.gives)
							results_due.push_back(row.res);
					end else if (gives) begin
						results_due.push_back(res);
					end
				end
				@(posedge clk);
			end
		end
		items_sent++;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_row('{rx: b, typed: 1'b0, gives: 1'b0, res: '0});
	endtask

	task automatic send_frame(input logic [LEN_W-1:0] len, input bit good);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		sum = '0;
		send_byte(start_delim);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		for (int i = 0; i < len; i++) begin
			b = BYTE_W'($urandom);
			sum = sum + b;
			send_byte(b);
		end
		if (good)
			send_byte(CHECKSUM_BASE - sum);
		else
			send_byte(BYTE_W'($urandom));
	endtask

	task automatic run_random(input int n);
		int sel;
		int target;
		int cut;
		int len;
		target = items_sent + n;
		while (items_sent < target) begin
			sel = $urandom_range(99);
			if (sel < 78) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12);
				send_frame(LEN_W'(len), $urandom_range(4) != 0);
			end else if (sel < 90) begin
				repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom));
			end else begin
				// header with a short payload cut off early
				len = $urandom_range(12, 2);
				cut = $urandom_range(len - 1);
				send_byte(start_delim);
				send_byte(8'h00);
				send_byte(BYTE_W'(len));
				repeat (cut) send_byte(BYTE_W'($urandom));
			end
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [APB_DW-1:0] wdata,
		output logic [APB_DW-1:0] rdata);
		bit done;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= DELIM_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			rdata = prdata;
			@(posedge clk);
		end while (!done);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (wr)
			start_delim = wdata[7:0];
	endtask

	initial begin
		logic [APB_DW-1:0] rd;
		logic [APB_DW-1:0] wd;
		logic [BYTE_W-1:0] delims [4];
		delims = '{8'h00, 8'hFF, 8'h00, 8'h7E};
		delims[2] = BYTE_W'($urandom);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, '0, rd);
		if (rd[7:0] !== START_DELIM_RESET)
			report_mismatch("start_delimiter after reset", 32'(rd[7:0]),
				32'(START_DELIM_RESET));
		foreach (directed_rows[i]) send_row(directed_rows[i]);
		run_random(220);
		for (int p = 0; p < 4; p++) begin
			settle();
			wd = $urandom;
			wd[7:0] = delims[p];
			apb_access(1'b1, wd, rd);
			apb_access(1'b0, '0, rd);
			if (rd[7:0] !== delims[p])
				report_mismatch("start_delimiter readback", 32'(rd[7:0]), 32'(delims[p]));
			// one phase runs with no idling on either side
			idle_pct = (p == 1) ? 0 : 7;
			stall_pct = (p == 1) ? 0 : 7;
			if (p == 2)
				send_frame(16'h0100, 1'b1);
			run_random(210);
			if (p == 3) begin
				// largest declared length, payload left unfinished
				send_byte(start_delim);
				send_byte(8'hFF);
				send_byte(8'hFF);
				repeat (8) send_byte(BYTE_W'($urandom));
			end
		end
		settle();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
